// File: rtl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared types and constants for the Cascade block parity engine.
// ----------------------------------------------------------------------------
package cbpe_pkg;

  // Key length; must be a power of two, at least 32
  localparam int KEY_BITS   = 1024;
  localparam int IDX_W      = $clog2(KEY_BITS);
  localparam int NUM_PASSES = 4;
  localparam int PASS_W     = 2;
  localparam int TBL_AW     = IDX_W + PASS_W;
  localparam int BLK_W      = 4;
  // log2 of the pass 0 block size (KEY_BITS / 16)
  localparam int BLK_LOG0   = IDX_W - 4;

  // Item action codes
  localparam logic [1:0] ACT_KEY_WRITE = 2'd0;
  localparam logic [1:0] ACT_TBL_WRITE = 2'd1;
  localparam logic [1:0] ACT_COMPUTE   = 2'd2;
  localparam logic [1:0] ACT_QUERY     = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [1:0]       pass_select;
    logic [IDX_W-1:0] position;
    logic             key_bit;
    logic [IDX_W-1:0] bit_index;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             parity;
    logic [1:0]       pass_number;
    logic [BLK_W-1:0] block_number;
    logic             is_query;
    logic             last_of_run;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic issue;      // launch next table slot of a compute walk
    logic cnt_clear;  // hold walk counter at zero; clear block accumulator when stage 2 is empty
  } cbpe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;   // walk counter at final slot of final table
    logic pipe_empty; // no compute slot in flight
  } cbpe_status_t;

endpackage

// File: rtl/cbpe_ctrl.sv
// ----------------------------------------------------------------------------
// cbpe_ctrl
// Controller: takes items, sequences the compute walk and drains the pipe.
// ----------------------------------------------------------------------------
module cbpe_ctrl
  import cbpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [1:0]   action,
  input  cbpe_status_t status,
  output cbpe_cmd_t    cmd,
  output logic         busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && action == ACT_COMPUTE) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.cnt_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Commands
  assign busy          = (state != ST_IDLE);
  assign cmd.accept    = start && (state == ST_IDLE);
  assign cmd.issue     = (state == ST_RUN);
  assign cmd.cnt_clear = (state != ST_RUN);

endmodule

// File: rtl/cbpe_datapath.sv
// ----------------------------------------------------------------------------
// cbpe_datapath
// Key store, permutation tables, walk counter, parity accumulators and the
// result register.
// ----------------------------------------------------------------------------
module cbpe_datapath
  import cbpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cbpe_cmd_t    cmd,
  input  item_t        item,
  output cbpe_status_t status,
  output result_t      result,
  output logic         result_valid
);

  // Memories
  logic             key_mem [KEY_BITS];
  logic [IDX_W-1:0] tbl_mem [NUM_PASSES*KEY_BITS];

  // Walk counter: {pass, slot}
  logic [TBL_AW-1:0] cnt;

  // Stage 1: table entry read
  logic              v1;
  logic [TBL_AW-1:0] tag1;
  logic [IDX_W-1:0]  tbl_q;

  // Stage 2: key bit read
  logic              v2c;
  logic [TBL_AW-1:0] tag2;
  logic              qv;
  logic              qlast;
  logic              key_q;
  logic [IDX_W-1:0]  key_addr;

  // Accumulators
  logic acc_c;
  logic acc_c_next;
  logic qpar;
  logic qpar_next;

  // Block boundary decode for the slot in stage 2
  logic [PASS_W-1:0] p2;
  logic [IDX_W-1:0]  s2;
  logic [IDX_W-1:0]  blk_mask;
  logic [BLK_W-1:0]  blk_shift;
  logic              blk_end;
  logic              key_we;
  logic              tbl_we;

  assign key_we = cmd.accept && item.action == ACT_KEY_WRITE;
  assign tbl_we = cmd.accept && item.action == ACT_TBL_WRITE;

  // Walk counter
  always_ff @(posedge clk) begin
    if (cmd.cnt_clear)  cnt <= '0;
    else if (cmd.issue) cnt <= cnt + TBL_AW'(1);
  end

  assign status.cnt_last   = cmd.issue && (&cnt);
  assign status.pipe_empty = !v1 && !v2c;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[{item.pass_select, item.position}] <= item.bit_index;
    tbl_q <= tbl_mem[cnt];
  end

  // Key memory: compute walk reads through the table, queries read directly
  assign key_addr = v1 ? tbl_q : item.bit_index;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[item.position] <= item.key_bit;
    key_q <= key_mem[key_addr];
  end

  // Pipeline control and tags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2c <= 1'b0;
      qv  <= 1'b0;
    end else begin
      v1  <= cmd.issue;
      v2c <= v1;
      qv  <= cmd.accept && item.action == ACT_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    tag1  <= cnt;
    tag2  <= tag1;
    qlast <= item.last;
  end

  // Block boundary: low (BLK_LOG0 + pass) slot bits all ones
  assign p2        = tag2[TBL_AW-1:IDX_W];
  assign s2        = tag2[IDX_W-1:0];
  assign blk_mask  = ~({IDX_W{1'b1}} << (BLK_LOG0 + int'(p2)));
  assign blk_shift = BLK_W'(s2 >> (BLK_LOG0 + int'(p2)));
  assign blk_end   = ((s2 & blk_mask) == blk_mask);

  // Accumulators
  always_comb begin
    acc_c_next = acc_c;
    if (v2c) acc_c_next = acc_c ^ key_q;
    qpar_next = qpar;
    if (qv) qpar_next = qpar ^ key_q;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clear && !v2c) begin
      acc_c <= 1'b0;
    end else if (v2c) begin
      acc_c <= blk_end ? 1'b0 : acc_c_next;
    end
    if (rst) begin
      qpar <= 1'b0;
    end else if (qv) begin
      qpar <= qlast ? 1'b0 : qpar_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (v2c && blk_end) || (qv && qlast);
    end
    if (qv) begin
      result.parity       <= qpar_next;
      result.pass_number  <= '0;
      result.block_number <= '0;
      result.is_query     <= 1'b1;
      result.last_of_run  <= 1'b1;
    end else begin
      result.parity       <= acc_c_next;
      result.pass_number  <= p2;
      result.block_number <= blk_shift;
      result.is_query     <= 1'b0;
      result.last_of_run  <= &tag2;
    end
  end

endmodule

// File: rtl/cascade_block_parity_engine.sv
// ----------------------------------------------------------------------------
// cascade_block_parity_engine
// Parity side of Cascade key reconciliation: key store, four permutation
// tables, block parity walk and index query accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a clock edge with start high and busy low. Key bit
//   and table writes leave busy low. Query items also go at one per cycle;
//   the answer passes through the key read and the result register after
//   the item marked last. A compute item raises busy and walks all four
//   tables, one table slot per cycle through a table read then a key read,
//   and busy stays high until the last slot has left the pipe. The 30 block
//   parities leave in pass then block order; the last is marked last_of_run.
//   Each result is shown for one cycle with result_valid high; the receiver
//   cannot stall, so it must take every result as it comes.
//   Synchronous reset returns the controller to idle, drops result_valid
//   and clears the query accumulator. Key and table contents are not
//   cleared; they are undefined until written.
// ----------------------------------------------------------------------------
module cascade_block_parity_engine
  import cbpe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output result_t result,
  output logic    result_valid
);

  cbpe_cmd_t    cmd;
  cbpe_status_t status;

  cbpe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cbpe_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

  // A taken compute item raises busy
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.action == ACT_COMPUTE |=> busy)
    else $error("compute item did not raise busy");

  // Walk pipeline is empty whenever the block is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> status.pipe_empty)
    else $error("compute slot in flight while idle");

  // Query answers carry zero pass and block
  a_query_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_query |->
      result.pass_number == 2'd0 && result.block_number == '0 && result.last_of_run)
    else $error("query answer with bad fields");

  // Final block parity is pass 3, block 1
  a_last_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_query && result.last_of_run |->
      result.pass_number == 2'd3 && result.block_number == 4'd1)
    else $error("last_of_run on wrong block");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Cascade block parity engine. It loads the key
// store and all four permutation tables, then runs edge-case items, a query
// accumulation that spans a compute walk, random traffic with sender gaps,
// a full drain pause and a gap-free tail. A shadow copy of the stores
// predicts every block parity and query answer, and a checker compares
// each strobed result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import cbpe_pkg::*;

  // Longest correct quiet stretch is the walk through one pass 3 block
  localparam int STALL_LIMIT = 8 * KEY_BITS;
  localparam int TAIL_CYCLES = 16;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  result_t result;
  logic    result_valid;

  cascade_block_parity_engine dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the block state
  logic                key_copy  [KEY_BITS];
  logic [IDX_W-1:0]    perm_copy [NUM_PASSES][KEY_BITS];
  logic                query_acc = 1'b0;

  result_t parities_due [$];

  bit idle_en       = 1'b1;
  int items_taken   = 0;
  int compute_runs  = 0;
  int query_answers = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  function automatic logic key_at(int idx);
    if (idx >= KEY_BITS) return 1'b0;
    return key_copy[idx];
  endfunction

  // Update the shadow state and queue the parities this item causes
  function automatic void predict_parities(item_t it);
    result_t r;
    logic    acc;
    int      nblk;
    int      span;
    int      k;
    case (it.action)
      ACT_KEY_WRITE: begin
        if (int'(it.position) < KEY_BITS) key_copy[it.position] = it.key_bit;
      end
      ACT_TBL_WRITE: begin
        if (int'(it.position) < KEY_BITS)
          perm_copy[it.pass_select][it.position] = it.bit_index;
      end
      ACT_COMPUTE: begin
        k = 0;
        for (int p = 0; p < NUM_PASSES; p++) begin
          nblk = 16 >> p;
          span = KEY_BITS / nblk;
          for (int b = 0; b < nblk; b++) begin
            acc = 1'b0;
            for (int j = 0; j < span; j++)
              acc ^= key_at(int'(perm_copy[p][b * span + j]));
            r.parity       = acc;
            r.pass_number  = 2'(p);
            r.block_number = BLK_W'(b);
            r.is_query     = 1'b0;
            r.last_of_run  = (k == 29);
            parities_due.push_back(r);
            k++;
          end
        end
        compute_runs++;
      end
      ACT_QUERY: begin
        query_acc ^= key_at(int'(it.bit_index));
        if (it.last) begin
          r.parity       = query_acc;
          r.pass_number  = '0;
          r.block_number = '0;
          r.is_query     = 1'b1;
          r.last_of_run  = 1'b1;
          parities_due.push_back(r);
          query_acc = 1'b0;
          query_answers++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk_item(logic [1:0] act, int sel, int pos, bit kb, int idx,
                                    bit lst);
    item_t it;
    it.action      = act;
    it.pass_select = 2'(sel);
    it.position    = IDX_W'(pos);
    it.key_bit     = kb;
    it.bit_index   = IDX_W'(idx);
    it.last        = lst;
    return it;
  endfunction

  function automatic item_t rand_item(logic [1:0] act);
    return mk_item(act, $urandom_range(0, 3), $urandom_range(0, KEY_BITS - 1),
                   1'($urandom_range(0, 1)), $urandom_range(0, KEY_BITS - 1),
                   1'($urandom_range(0, 1)));
  endfunction

  // Send one item; called in the time step of a rising edge
  task automatic issue_item(item_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_parities(it);
    items_taken++;
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (parities_due.size() != 0);
  endtask

  task automatic query_run(int len, bit close);
    item_t it;
    for (int i = 0; i < len; i++) begin
      it = rand_item(ACT_QUERY);
      it.last = close && (i == len - 1);
      issue_item(it);
    end
  endtask

  // Every key bit and table slot written before anything reads them
  task automatic test_load_stores();
    for (int i = 0; i < KEY_BITS; i++)
      issue_item(mk_item(ACT_KEY_WRITE, $urandom_range(0, 3), i,
                         1'($urandom_range(0, 1)), $urandom_range(0, KEY_BITS - 1),
                         1'($urandom_range(0, 1))));
    for (int p = 0; p < NUM_PASSES; p++)
      for (int s = 0; s < KEY_BITS; s++)
        issue_item(mk_item(ACT_TBL_WRITE, p, s, 1'($urandom_range(0, 1)),
                           $urandom_range(0, KEY_BITS - 1), 1'($urandom_range(0, 1))));
  endtask

  // Field extremes and every action at least once
  task automatic test_field_extremes();
    issue_item(mk_item(ACT_KEY_WRITE, 3, 0, 1'b1, KEY_BITS - 1, 1'b1));
    issue_item(mk_item(ACT_KEY_WRITE, 0, KEY_BITS - 1, 1'b0, 0, 1'b0));
    issue_item(mk_item(ACT_TBL_WRITE, 0, 0, 1'b1, KEY_BITS - 1, 1'b1));
    issue_item(mk_item(ACT_TBL_WRITE, 3, KEY_BITS - 1, 1'b0, 0, 1'b0));
    issue_item(mk_item(ACT_TBL_WRITE, 1, KEY_BITS - 1, 1'b0, KEY_BITS - 1, 1'b0));
    issue_item(mk_item(ACT_TBL_WRITE, 2, 0, 1'b1, 0, 1'b1));
    issue_item(mk_item(ACT_QUERY, 3, KEY_BITS - 1, 1'b1, 0, 1'b1));
    issue_item(mk_item(ACT_QUERY, 0, 0, 1'b0, KEY_BITS - 1, 1'b1));
    // repeated index cancels out of the accumulator
    issue_item(mk_item(ACT_QUERY, 0, 0, 1'b0, 0, 1'b0));
    issue_item(mk_item(ACT_QUERY, 0, 0, 1'b0, KEY_BITS - 1, 1'b0));
    issue_item(mk_item(ACT_QUERY, 0, 0, 1'b0, 0, 1'b1));
    issue_item(mk_item(ACT_COMPUTE, 3, KEY_BITS - 1, 1'b1, KEY_BITS - 1, 1'b1));
    issue_item(mk_item(ACT_KEY_WRITE, 1, KEY_BITS - 1, 1'b1, 5, 1'b0));
    issue_item(mk_item(ACT_QUERY, 0, 0, 1'b0, KEY_BITS - 1, 1'b1));
  endtask

  // Query accumulator must survive a compute walk; answer just before a walk
  task automatic test_query_across_compute();
    query_run(2, 1'b0);
    issue_item(rand_item(ACT_COMPUTE));
    query_run(1, 1'b1);
    issue_item(rand_item(ACT_COMPUTE));
    query_run(3, 1'b1);
  endtask

  task automatic test_random_traffic(int n);
    int first;
    int roll;
    first = items_taken;
    while (items_taken - first < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)      issue_item(rand_item(ACT_KEY_WRITE));
      else if (roll < 50) issue_item(rand_item(ACT_TBL_WRITE));
      else if (roll < 53) issue_item(rand_item(ACT_COMPUTE));
      else if (roll < 93) query_run($urandom_range(1, 6), 1'b1);
      else                query_run($urandom_range(1, 3), 1'b0);
    end
  endtask

  task automatic test_drain_pause();
    query_run(4, 1'b1);
    issue_item(rand_item(ACT_COMPUTE));
    wait_for_drain();
    query_run(2, 1'b1);
  endtask

  // Tail of the run with no sender gaps
  task automatic test_back_to_back();
    idle_en = 1'b0;
    issue_item(rand_item(ACT_COMPUTE));
    query_run(1, 1'b1);
    test_random_traffic(60);
    issue_item(rand_item(ACT_COMPUTE));
  endtask

  task automatic log_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: want par=%0b pass=%0d blk=%0d q=%0b last=%0b",
               $time, what, want.parity, want.pass_number, want.block_number,
               want.is_query, want.last_of_run);
      $display("    got par=%0b pass=%0d blk=%0d q=%0b last=%0b",
               got.parity, got.pass_number, got.block_number, got.is_query,
               got.last_of_run);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (parities_due.size() == 0) begin
        log_mismatch("result with none pending", '0, result);
      end else begin
        want = parities_due.pop_front();
        if (result.parity !== want.parity || result.pass_number !== want.pass_number ||
            result.block_number !== want.block_number ||
            result.is_query !== want.is_query ||
            result.last_of_run !== want.last_of_run)
          log_mismatch("result mismatch", want, result);
      end
    end
  end

  // Watchdog on cycles with no item and no result taken
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || result_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d results pending", quiet_cycles,
                 parities_due.size());
        $display("cascade_block_parity_engine regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_load_stores();
    test_field_extremes();
    test_query_across_compute();
    test_random_traffic(200);
    test_drain_pause();
    test_random_traffic(200);
    test_back_to_back();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items: %0d compute walks, %0d query answers", items_taken,
             compute_runs, query_answers);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && parities_due.size() == 0) begin
      $display("cascade_block_parity_engine regression: pass");
    end else begin
      $display("cascade_block_parity_engine regression: fail");
    end
    $finish;
  end

endmodule

// File: cascade_block_parity_engine.f
rtl/cbpe_pkg.sv
rtl/cbpe_ctrl.sv
rtl/cbpe_datapath.sv
rtl/cascade_block_parity_engine.sv
tb/tb.sv
